/* rtl/sbb_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbb_pkg
// Types, constants and the 1-2-1 tap shared by the blur modules.
// ============================================================================
package sbb_pkg;

    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int PAD_W        = IMAGE_WIDTH + 2;
    localparam int PAD_H        = IMAGE_HEIGHT + 2;
    localparam int COL_W        = $clog2(PAD_W);
    localparam int ROW_W        = $clog2(PAD_H);
    localparam int ADDR_W       = $clog2(IMAGE_WIDTH);

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] blurred;
        logic       end_of_row;
        logic       end_of_frame;
    } blur_item_t;

    typedef struct packed {
        logic [7:0] newer;
        logic [7:0] older;
    } line_pair_t;

    typedef struct packed {
        logic              has_h;
        logic              has_out;
        logic              end_of_row;
        logic              end_of_frame;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        h;
    } stage_ctl_t;

    function automatic logic [7:0] tap121(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic [9:0] sum;
        sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
        return sum[9:2];
    endfunction

endpackage

/* rtl/separable_binomial_blur_3x3.sv */
`timescale 1ns / 1ps
// ============================================================================
// separable_binomial_blur_3x3
// 3x3 binomial blur over a padded 8-bit frame, one pixel per clock while the output is not stalled.
// ============================================================================
// Pipeline: the horizontal result and the line memory read of an accepted pixel are
// registered in the s1 stage, then its result is loaded into the output register once that is free.
// Throughput: one pixel per cycle while the output is not stalled; one line memory word per output
// column holds both previous rows, read once and written once per pixel from the third column on.
// Reset clears the frame position, the pixel window and all valid flags; the
// line memory is not cleared, as the first two rows of every frame fill it.
module separable_binomial_blur_3x3
    import sbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_stall,
    input  pix_item_t  pix,
    output logic       blur_valid,
    input  logic       blur_stall,
    output blur_item_t blur
);

    logic              s1_free;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_valid;
    stage_ctl_t        s1;
    line_pair_t        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    line_pair_t        wr_data;

    sbb_hstage u_hstage (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix       (pix),
        .s1_free   (s1_free),
        .pix_stall (pix_stall),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    sbb_linebuf u_linebuf (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sbb_vstage u_vstage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1         (s1),
        .rd_data    (rd_data),
        .s1_free    (s1_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .blur_valid (blur_valid),
        .blur       (blur),
        .blur_stall (blur_stall)
    );

endmodule

/* rtl/sbb_hstage.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbb_hstage
// Input stage: frame position, horizontal 1-2-1 tap and line buffer read.
// ============================================================================
module sbb_hstage
    import sbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    input  pix_item_t         pix,
    input  logic              s1_free,
    output logic              pix_stall,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              s1_valid,
    output stage_ctl_t        s1
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [7:0]       prev0_reg;
    logic [7:0]       prev1_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    stage_ctl_t       s1_reg;
    stage_ctl_t       s1_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             accept;
    logic             col_last;
    logic             row_last;
    logic [COL_W-1:0] x_full;

    assign pix_stall = !s1_free;
    assign accept    = pix_valid && s1_free;

    always_comb
    begin
        col_cur  = pix.frame_start ? '0 : col_reg;
        row_cur  = pix.frame_start ? '0 : row_reg;
        col_last = (col_cur == COL_W'(PAD_W - 1));
        row_last = (row_cur == ROW_W'(PAD_H - 1));
        x_full   = col_cur - COL_W'(2);

        s1_next.has_h        = (col_cur >= COL_W'(2));
        s1_next.has_out      = s1_next.has_h && (row_cur >= ROW_W'(2));
        s1_next.end_of_row   = col_last;
        s1_next.end_of_frame = col_last && row_last;
        s1_next.addr         = x_full[ADDR_W-1:0];
        s1_next.h            = tap121(prev0_reg, prev1_reg, pix.pixel);

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end

        s1_valid_next = s1_free ? accept : s1_valid_reg;
    end

    assign rd_en    = accept && s1_next.has_h;
    assign rd_addr  = s1_next.addr;
    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            prev0_reg    <= '0;
            prev1_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                prev0_reg <= prev1_reg;
                prev1_reg <= pix.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

/* rtl/sbb_linebuf.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbb_linebuf
// Line memory holding the horizontal results of the two previous rows.
// ============================================================================
module sbb_linebuf
    import sbb_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output line_pair_t        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_pair_t        wr_data
);

    line_pair_t mem [IMAGE_WIDTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sbb_vstage.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbb_vstage
// Vertical 1-2-1 tap, line memory update and output register.
// ============================================================================
module sbb_vstage
    import sbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  stage_ctl_t        s1,
    input  line_pair_t        rd_data,
    output logic              s1_free,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output line_pair_t        wr_data,
    output logic              blur_valid,
    output blur_item_t        blur,
    input  logic              blur_stall
);

    logic       blur_valid_reg;
    logic       blur_valid_next;
    blur_item_t blur_reg;
    blur_item_t blur_next;
    logic       out_free;
    logic       s1_go;
    logic       load_out;

    assign out_free = !blur_valid_reg || !blur_stall;
    assign s1_go    = s1_valid && (!s1.has_out || out_free);
    assign s1_free  = !s1_valid || s1_go;
    assign load_out = s1_go && s1.has_out;

    assign wr_en         = s1_go && s1.has_h;
    assign wr_addr       = s1.addr;
    assign wr_data.newer = s1.h;
    assign wr_data.older = rd_data.newer;

    always_comb
    begin
        blur_next.blurred      = tap121(rd_data.older, rd_data.newer, s1.h);
        blur_next.end_of_row   = s1.end_of_row;
        blur_next.end_of_frame = s1.end_of_frame;
        if (load_out)
        begin
            blur_valid_next = 1'b1;
        end
        else if (!blur_stall)
        begin
            blur_valid_next = 1'b0;
        end
        else
        begin
            blur_valid_next = blur_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_valid_reg <= 1'b0;
        end
        else
        begin
            blur_valid_reg <= blur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            blur_reg <= blur_next;
        end
    end

    assign blur_valid = blur_valid_reg;
    assign blur       = blur_reg;

endmodule

/* rtl/sbb_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbb_checker
// Port-level checks for the blur block, bound to the top level.
// ============================================================================
module sbb_checker
    import sbb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_stall,
    input pix_item_t  pix,
    input logic       blur_valid,
    input logic       blur_stall,
    input blur_item_t blur
);

    // The input side only stalls when a result is waiting and held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (blur_valid && blur_stall))
        else $error("input stalled without a held result");

    a_eof_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (blur_valid && blur.end_of_frame) |-> blur.end_of_row)
        else $error("end of frame without end of row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (blur_valid && blur_stall) |=> (blur_valid && $stable(blur)))
        else $error("stalled result changed");

    // A stalled input item stays in place until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_stall) |=> (pix_valid && $stable(pix)))
        else $error("stalled input item changed");

endmodule

bind separable_binomial_blur_3x3 sbb_checker u_sbb_checker (.*);
